// File: hw/rtl/tss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the table section syncer: operation codes,
// the decoded command and the item that moves from front to back.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int VER_W       = 5;
    localparam int SEC_W       = 8;
    localparam int SEG_RAW_W   = 9;
    localparam int OP_W        = 2;
    localparam int SEG_COUNT   = 32;
    localparam int SEG_IDX_W   = 5;
    localparam int SEG_SEC_W   = 3;
    localparam int SEG_SIZE    = 8;
    localparam int EXP_W       = 9;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes as they arrive on s_tuser.
    localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OP_W-1:0] OP_PROC  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        CMD_CHECK,
        CMD_PROC,
        CMD_CLEAR,
        CMD_NOP
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [VER_W-1:0]     version;
        logic [SEC_W-1:0]     sec;
        logic [SEC_W-1:0]     last;
        logic                 seg_given;
        logic [SEC_W-1:0]     seg_last;
    } item_t;

endpackage

`default_nettype wire

// File: hw/rtl/tss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_front
// Accepts input items, decodes the operation and resolves the segment's last
// section before the item enters the queue.
// ----------------------------------------------------------------------------
module tss_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: version[4:0], section_number[12:5], last_section_number[20:13],
    //          segment_last_section[29:21], zero[31:30]
    input  wire logic [tss_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [tss_pkg::OP_W-1:0]      s_tuser,
    output logic                               push_valid,
    output tss_pkg::item_t                     push_item,
    input  wire logic                          push_ready
);

    logic [tss_pkg::SEC_W-1:0]     sec;
    logic [tss_pkg::SEC_W-1:0]     last;
    logic [tss_pkg::SEG_RAW_W-1:0] seg_raw;

    assign sec     = s_tdata[12:5];
    assign last    = s_tdata[20:13];
    assign seg_raw = s_tdata[29:21];

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_item         = '0;
        push_item.version = s_tdata[4:0];
        push_item.sec     = sec;
        push_item.last    = last;

        unique case (s_tuser)
            tss_pkg::OP_CHECK: push_item.cmd = tss_pkg::CMD_CHECK;
            tss_pkg::OP_PROC:  push_item.cmd = tss_pkg::CMD_PROC;
            tss_pkg::OP_CLEAR: push_item.cmd = tss_pkg::CMD_CLEAR;
            default:           push_item.cmd = tss_pkg::CMD_NOP;
        endcase

        // A negative segment end means none was given; inside the table's
        // last segment the table's last section stands in for it.
        push_item.seg_given = ~seg_raw[tss_pkg::SEG_RAW_W-1];
        push_item.seg_last  = seg_raw[tss_pkg::SEC_W-1:0];
        if (seg_raw[tss_pkg::SEG_RAW_W-1] &&
            (sec[tss_pkg::SEC_W-1:tss_pkg::SEG_SEC_W] ==
             last[tss_pkg::SEC_W-1:tss_pkg::SEG_SEC_W])) begin
            push_item.seg_given = 1'b1;
            push_item.seg_last  = last;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_queue
// Small register queue between the front and the back so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module tss_queue #(
    parameter int DEPTH = tss_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    input  wire tss_pkg::item_t push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output tss_pkg::item_t      pop_item,
    input  wire logic           pop_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tss_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tss_back
// Executes queued items against the tracker state (version, sync, expected
// section, section flags, segment done mask) and registers the result.
// ----------------------------------------------------------------------------
module tss_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          pop_valid,
    input  wire tss_pkg::item_t                pop_item,
    output logic                               pop_ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: verdict[0], table_complete[1], zero[7:2]
    output logic [tss_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SEG_COUNT = tss_pkg::SEG_COUNT;
    localparam int SEG_SIZE  = tss_pkg::SEG_SIZE;
    localparam int IDX_W     = tss_pkg::SEG_IDX_W;
    localparam int BIT_W     = tss_pkg::SEG_SEC_W;
    localparam int EXP_W     = tss_pkg::EXP_W;
    localparam int SEC_W     = tss_pkg::SEC_W;
    localparam int VER_W     = tss_pkg::VER_W;

    logic                 random_order_reg;
    logic [VER_W-1:0]     stored_ver_reg, stored_ver_next;
    logic                 ver_valid_reg, ver_valid_next;
    logic [EXP_W-1:0]     expected_reg, expected_next;
    logic                 synced_reg, synced_next;
    logic                 complete_reg, complete_next;
    logic [SEG_COUNT-1:0] seg_done_reg, seg_done_next;
    logic [SEG_SIZE-1:0]  flags_reg [SEG_COUNT];
    logic                 m_valid_reg, m_valid_next;
    logic                 verdict_reg, verdict_next;
    logic                 m_complete_reg, m_complete_next;

    logic                 do_pop;
    logic                 flags_clr;
    logic                 flags_we;
    logic [SEG_SIZE-1:0]  flags_wdata;
    logic [IDX_W-1:0]     idx;
    logic [BIT_W-1:0]     bit_sel;
    logic [IDX_W-1:0]     last_idx;
    logic [SEG_SIZE-1:0]  row;
    logic [SEG_SIZE-1:0]  row_eff;
    logic [SEG_SIZE-1:0]  row_new;
    logic [SEG_SIZE-1:0]  seg_mask;
    logic [SEG_COUNT-1:0] seg_done_new;
    logic [SEG_COUNT-1:0] all_mask;
    logic                 new_ver;
    logic                 comp_eff;
    logic                 synced_eff;
    logic [EXP_W-1:0]     expected_eff;

    assign idx      = pop_item.sec[SEC_W-1:BIT_W];
    assign bit_sel  = pop_item.sec[BIT_W-1:0];
    assign last_idx = pop_item.last[SEC_W-1:BIT_W];
    assign row      = flags_reg[idx];

    // The output register frees up in the same cycle that it is taken.
    assign pop_ready = !m_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(tss_pkg::M_TDATA_W - 2){1'b0}}, m_complete_reg, verdict_reg};

    always_comb begin
        stored_ver_next = stored_ver_reg;
        ver_valid_next  = ver_valid_reg;
        expected_next   = expected_reg;
        synced_next     = synced_reg;
        complete_next   = complete_reg;
        seg_done_next   = seg_done_reg;
        flags_clr       = 1'b0;
        flags_we        = 1'b0;
        flags_wdata     = '0;
        verdict_next    = verdict_reg;
        m_complete_next = m_complete_reg;
        m_valid_next    = m_valid_reg;

        new_ver      = !ver_valid_reg || (pop_item.version != stored_ver_reg);
        comp_eff     = new_ver ? 1'b0 : complete_reg;
        synced_eff   = new_ver ? 1'b0 : synced_reg;
        expected_eff = new_ver ? '0 : expected_reg;
        row_eff      = new_ver ? '0 : row;

        row_new  = row | (SEG_SIZE'(1) << bit_sel);
        seg_mask = pop_item.seg_given ?
                   ({SEG_SIZE{1'b1}} >> (BIT_W'(SEG_SIZE - 1) - pop_item.seg_last[BIT_W-1:0])) :
                   {SEG_SIZE{1'b1}};
        seg_done_new = seg_done_reg |
                       ((row_new == seg_mask) ? (SEG_COUNT'(1) << idx) : '0);
        all_mask = {SEG_COUNT{1'b1}} >> (IDX_W'(SEG_COUNT - 1) - last_idx);

        if (do_pop) begin
            logic verdict;
            verdict = 1'b0;
            unique case (pop_item.cmd)
                tss_pkg::CMD_CHECK: begin
                    if (new_ver) begin
                        expected_next   = '0;
                        synced_next     = 1'b0;
                        complete_next   = 1'b0;
                        seg_done_next   = '0;
                        flags_clr       = 1'b1;
                        stored_ver_next = pop_item.version;
                        ver_valid_next  = 1'b1;
                    end
                    if (!comp_eff) begin
                        if (random_order_reg) begin
                            verdict = !row_eff[bit_sel];
                        end else if (!synced_eff) begin
                            // Waiting for section zero to start the sequence.
                            if (pop_item.sec == '0) begin
                                synced_next   = 1'b1;
                                expected_next = '0;
                                verdict       = !row_eff[bit_sel];
                            end
                        end else begin
                            verdict = ({1'b0, pop_item.sec} == expected_eff) &&
                                      !row_eff[bit_sel];
                        end
                    end
                end
                tss_pkg::CMD_PROC: begin
                    flags_we    = 1'b1;
                    flags_wdata = row_new;
                    if (!random_order_reg) begin
                        expected_next = expected_reg + 1'b1;
                        // Last section of a segment: jump to the next segment.
                        if (pop_item.seg_given && (pop_item.sec == pop_item.seg_last)) begin
                            expected_next = {1'b0, idx, {BIT_W{1'b0}}} +
                                            EXP_W'(SEG_SIZE);
                        end
                    end
                    seg_done_next = seg_done_new;
                    complete_next = (seg_done_new == all_mask);
                    verdict       = (seg_done_new == all_mask);
                end
                tss_pkg::CMD_CLEAR: begin
                    stored_ver_next = '0;
                    ver_valid_next  = 1'b0;
                    expected_next   = '0;
                    synced_next     = 1'b0;
                    complete_next   = 1'b0;
                    seg_done_next   = '0;
                    flags_clr       = 1'b1;
                end
                default: begin
                end
            endcase
            m_valid_next    = 1'b1;
            verdict_next    = verdict;
            m_complete_next = complete_next;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            random_order_reg <= 1'b0;
            stored_ver_reg   <= '0;
            ver_valid_reg    <= 1'b0;
            expected_reg     <= '0;
            synced_reg       <= 1'b0;
            complete_reg     <= 1'b0;
            seg_done_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                random_order_reg <= cfg_wdata;
            end
            stored_ver_reg <= stored_ver_next;
            ver_valid_reg  <= ver_valid_next;
            expected_reg   <= expected_next;
            synced_reg     <= synced_next;
            complete_reg   <= complete_next;
            seg_done_reg   <= seg_done_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg    <= verdict_next;
        m_complete_reg <= m_complete_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flags_clr) begin
            for (int i = 0; i < SEG_COUNT; i++) begin
                flags_reg[i] <= '0;
            end
        end else if (flags_we) begin
            flags_reg[idx] <= flags_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/table_section_syncer.sv
`default_nettype none
// Path: an accepted item is written into the queue register and then popped into
// the back unit's result register, where m_tvalid rises with its result.
// Throughput: one item per cycle while m_tready stays high; the back unit retires
// one queued item per cycle through a single state update and a registered result.
// Reset: aresetn clears the queue, the tracker state and random_order at once;
// no clearing pass is needed and s_tready is already high when reset is released.
// ----------------------------------------------------------------------------
// table_section_syncer
// Tracks which sections of a broadcast table version have been received and
// reports whether a section is wanted and whether the table is complete.
// ----------------------------------------------------------------------------
module table_section_syncer #(
    parameter int QUEUE_DEPTH = tss_pkg::QUEUE_DEPTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    // cfg_wdata: random_order[0]
    input  wire logic                          cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: version[4:0], section_number[12:5], last_section_number[20:13],
    //          segment_last_section[29:21], zero[31:30]
    input  wire logic [tss_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [tss_pkg::OP_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: verdict[0], table_complete[1], zero[7:2]
    output logic [tss_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic           push_valid;
    logic           push_ready;
    tss_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    tss_pkg::item_t pop_item;

    tss_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    tss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    tss_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
